// ===== src/l1c_pkg.sv =====
`timescale 1ns / 1ps

package l1c_pkg;

    localparam int LINES      = 256;
    localparam int WB_ENTRIES = 8;
    localparam int LINE_AW    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int BUF_AW     = (WB_ENTRIES > 1) ? $clog2(WB_ENTRIES) : 1;

    localparam int KIND_W   = 4;
    localparam int WHERE_W  = 2;
    localparam int LIDX_W   = 8;
    localparam int BIDX_W   = 3;
    localparam int STATE_W  = 4;

    typedef enum logic [3:0] {
        ST_I   = 4'd0,
        ST_ISE = 4'd1,
        ST_IM  = 4'd2,
        ST_S   = 4'd3,
        ST_E   = 4'd4,
        ST_M   = 4'd5,
        ST_SM  = 4'd6,
        ST_MI  = 4'd7,
        ST_SI  = 4'd8,
        ST_NP  = 4'd9
    } line_state_t;

    typedef enum logic [3:0] {
        KIND_REPLACE    = 4'd0,
        KIND_LOAD       = 4'd1,
        KIND_STORE      = 4'd2,
        KIND_DATA_SH    = 4'd3,
        KIND_DATA_EX    = 4'd4,
        KIND_UPG_ACK    = 4'd5,
        KIND_INV        = 4'd6,
        KIND_WB_ACK     = 4'd7,
        KIND_REPL_ACK   = 4'd8,
        KIND_READ_FWD   = 4'd9,
        KIND_READEX_FWD = 4'd10,
        KIND_FLUSH      = 4'd11
    } kind_t;

    typedef enum logic [1:0] {
        LOC_ABSENT = 2'd0,
        LOC_CACHE  = 2'd1,
        LOC_BUFFER = 2'd2
    } where_t;

    typedef enum logic [1:0] {
        SR_NONE  = 2'd0,
        SR_POLL  = 2'd1,
        SR_EVENT = 2'd2
    } stall_t;

    typedef enum logic [3:0] {
        DN_NONE     = 4'd0,
        DN_READ     = 4'd1,
        DN_READEX   = 4'd2,
        DN_UPGRADE  = 4'd3,
        DN_REPLACE  = 4'd4,
        DN_WB_CLEAN = 4'd5,
        DN_WB       = 4'd6,
        DN_INV_ACK  = 4'd7,
        DN_DATA_SH  = 4'd8,
        DN_DATA_EX  = 4'd9
    } down_t;

    typedef enum logic [1:0] {
        UP_NONE = 2'd0,
        UP_DATA = 2'd1,
        UP_INV  = 2'd2
    } up_t;

    typedef enum logic [1:0] {
        MS_NONE  = 2'd0,
        MS_ALLOC = 2'd1,
        MS_ENQ   = 2'd2,
        MS_DRAIN = 2'd3
    } mshr_cmd_t;

    typedef enum logic [1:0] {
        BC_NONE    = 2'd0,
        BC_ALLOC   = 2'd1,
        BC_RELEASE = 2'd2
    } buf_cmd_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_HIT         = 3'd1,
        EV_DEMAND_MISS = 3'd2,
        EV_COH_MISS    = 3'd3,
        EV_PART_HIT    = 3'd4,
        EV_WB_START    = 3'd5,
        EV_WB_DONE     = 3'd6,
        EV_STALL       = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        OC_TRANS  = 2'd0,
        OC_STALL  = 2'd1,
        OC_ERROR  = 2'd2,
        OC_IGNORE = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [3:0] new_state;
        logic [1:0] stall_res;
        logic       error;
        logic [3:0] down_first;
        logic       down_to_requester;
        logic       down_addr_only;
        logic       down_second_readex;
        logic [1:0] up_message;
        logic [1:0] mshr_command;
        logic [1:0] buffer_command;
        logic       store_data;
        logic [2:0] event_res;
    } rsp_t;

    typedef struct packed {
        logic       trans;
        logic [3:0] nxt;
        logic       alloc;
        logic [3:0] alloc_state;
    } upd_t;

endpackage

// ===== src/l1c_req_if.sv =====
`timescale 1ns / 1ps

interface l1c_req_if;
    import l1c_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [WHERE_W-1:0]  found_in;
    logic [LIDX_W-1:0]   line_index;
    logic [BIDX_W-1:0]   buffer_index;
    logic [1:0]          insert_stall;
    logic                mshr_free;
    logic                mshr_room;
    logic                buffer_free;

    modport source (
        output valid, kind, found_in, line_index, buffer_index,
               insert_stall, mshr_free, mshr_room, buffer_free,
        input  ready
    );

    modport sink (
        input  valid, kind, found_in, line_index, buffer_index,
               insert_stall, mshr_free, mshr_room, buffer_free,
        output ready
    );
endinterface

// ===== src/l1c_rsp_if.sv =====
`timescale 1ns / 1ps

interface l1c_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] new_state;
    logic [1:0] stall_res;
    logic       error;
    logic [3:0] down_first;
    logic       down_to_requester;
    logic       down_addr_only;
    logic       down_second_readex;
    logic [1:0] up_message;
    logic [1:0] mshr_command;
    logic [1:0] buffer_command;
    logic       store_data;
    logic [2:0] event_res;

    modport source (
        output valid, new_state, stall_res, error, down_first, down_to_requester,
               down_addr_only, down_second_readex, up_message, mshr_command,
               buffer_command, store_data, event_res,
        input  ready
    );

    modport sink (
        input  valid, new_state, stall_res, error, down_first, down_to_requester,
               down_addr_only, down_second_readex, up_message, mshr_command,
               buffer_command, store_data, event_res,
        output ready
    );
endinterface

// ===== src/l1c_line_store.sv =====
`timescale 1ns / 1ps

module l1c_line_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [l1c_pkg::LINE_AW-1:0]  rd_addr,
    output logic [l1c_pkg::STATE_W-1:0]  rd_data,
    input  logic                         wr_en,
    input  logic [l1c_pkg::LINE_AW-1:0]  wr_addr,
    input  logic [l1c_pkg::STATE_W-1:0]  wr_data
);
    import l1c_pkg::*;

    logic [STATE_W-1:0] mem [LINES];
    logic [LINES-1:0]   line_valid_reg;
    logic [STATE_W-1:0] rd_mem_reg;
    logic               rd_valid_reg;

    // state array, no reset; unwritten entries read as I via valid bits
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_mem_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                line_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= line_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : ST_I;
endmodule

// ===== src/l1c_transition.sv =====
`timescale 1ns / 1ps

module l1c_transition (
    input  logic [l1c_pkg::STATE_W-1:0] cur,
    input  logic [l1c_pkg::KIND_W-1:0]  kind,
    input  logic [1:0]                  insert_stall,
    input  logic                        mshr_free,
    input  logic                        mshr_room,
    input  logic                        buffer_free,
    output l1c_pkg::rsp_t               rsp,
    output l1c_pkg::upd_t               upd
);
    import l1c_pkg::*;

    outcome_t           outcome;
    logic [1:0]         stall;
    logic [STATE_W-1:0] nxt;
    logic               alloc;
    logic [STATE_W-1:0] alloc_state;
    rsp_t               r;

    always_comb
    begin
        outcome     = OC_TRANS;
        stall       = SR_NONE;
        nxt         = ST_I;
        alloc       = 1'b0;
        alloc_state = ST_MI;
        r           = '0;

        if (kind > KIND_FLUSH)
        begin
            outcome = OC_ERROR;
        end
        else
        begin
            case (cur)
                ST_NP, ST_I:
                begin
                    if (kind inside {KIND_LOAD, KIND_STORE})
                    begin
                        if (cur == ST_NP && insert_stall != SR_NONE)
                        begin
                            outcome = OC_STALL;
                            stall   = (insert_stall == SR_POLL) ? SR_POLL : SR_EVENT;
                        end
                        else if (!mshr_free || !mshr_room)
                        begin
                            outcome = OC_STALL;
                            stall   = SR_POLL;
                        end
                        else
                        begin
                            r.mshr_command   = MS_ALLOC;
                            r.down_first     = (kind == KIND_LOAD) ? DN_READ : DN_READEX;
                            r.down_addr_only = 1'b1;
                            nxt              = (kind == KIND_LOAD) ? ST_ISE : ST_IM;
                            r.event_res      = EV_DEMAND_MISS;
                        end
                    end
                    else if (kind == KIND_WB_ACK || (cur == ST_NP && kind == KIND_INV))
                    begin
                        outcome = OC_IGNORE;
                    end
                    else
                    begin
                        outcome = OC_ERROR;
                    end
                end
                ST_IM:
                begin
                    if (kind == KIND_DATA_EX)
                    begin
                        r.store_data   = 1'b1;
                        r.mshr_command = MS_DRAIN;
                        nxt            = ST_M;
                    end
                    else if (kind inside {KIND_READ_FWD, KIND_READEX_FWD, KIND_INV})
                    begin
                        outcome = OC_STALL;
                        stall   = SR_EVENT;
                    end
                    else if (kind inside {KIND_LOAD, KIND_STORE})
                    begin
                        if (!mshr_room)
                        begin
                            outcome = OC_STALL;
                            stall   = SR_POLL;
                        end
                        else
                        begin
                            r.mshr_command = MS_ENQ;
                            nxt            = cur;
                            r.event_res    = EV_PART_HIT;
                        end
                    end
                    else if (kind == KIND_WB_ACK)
                    begin
                        outcome = OC_IGNORE;
                    end
                    else
                    begin
                        outcome = OC_ERROR;
                    end
                end
                ST_ISE:
                begin
                    if (kind inside {KIND_DATA_SH, KIND_DATA_EX})
                    begin
                        r.store_data   = 1'b1;
                        r.mshr_command = MS_DRAIN;
                        nxt            = (kind == KIND_DATA_SH) ? ST_S : ST_E;
                    end
                    else if (kind inside {KIND_READ_FWD, KIND_READEX_FWD, KIND_INV,
                                          KIND_STORE})
                    begin
                        outcome = OC_STALL;
                        stall   = SR_EVENT;
                    end
                    else if (kind == KIND_LOAD)
                    begin
                        if (!mshr_room)
                        begin
                            outcome = OC_STALL;
                            stall   = SR_POLL;
                        end
                        else
                        begin
                            r.mshr_command = MS_ENQ;
                            nxt            = cur;
                            r.event_res    = EV_PART_HIT;
                        end
                    end
                    else if (kind == KIND_WB_ACK)
                    begin
                        outcome = OC_IGNORE;
                    end
                    else
                    begin
                        outcome = OC_ERROR;
                    end
                end
                ST_S:
                begin
                    if (kind == KIND_LOAD)
                    begin
                        r.up_message = UP_DATA;
                        r.event_res  = EV_HIT;
                        nxt          = ST_S;
                    end
                    else if (kind == KIND_STORE)
                    begin
                        if (!mshr_free || !mshr_room)
                        begin
                            outcome = OC_STALL;
                            stall   = SR_POLL;
                        end
                        else
                        begin
                            r.mshr_command   = MS_ALLOC;
                            r.down_first     = DN_UPGRADE;
                            r.down_addr_only = 1'b1;
                            nxt              = ST_SM;
                            r.event_res      = EV_COH_MISS;
                        end
                    end
                    else if (kind == KIND_REPLACE)
                    begin
                        if (!buffer_free)
                        begin
                            outcome = OC_STALL;
                            stall   = SR_POLL;
                        end
                        else
                        begin
                            alloc            = 1'b1;
                            alloc_state      = ST_SI;
                            r.buffer_command = BC_ALLOC;
                            r.down_first     = DN_REPLACE;
                            r.down_addr_only = 1'b1;
                            r.event_res      = EV_WB_START;
                            nxt              = ST_I;
                        end
                    end
                    else if (kind == KIND_READ_FWD)
                    begin
                        r.down_first        = DN_DATA_SH;
                        r.down_to_requester = 1'b1;
                        nxt                 = cur;
                    end
                    else if (kind == KIND_INV)
                    begin
                        r.down_first     = DN_INV_ACK;
                        r.down_addr_only = 1'b1;
                        r.up_message     = UP_INV;
                        nxt              = ST_I;
                    end
                    else if (kind == KIND_WB_ACK)
                    begin
                        outcome = OC_IGNORE;
                    end
                    else
                    begin
                        outcome = OC_ERROR;
                    end
                end
                ST_E, ST_M:
                begin
                    if (kind inside {KIND_LOAD, KIND_STORE})
                    begin
                        r.up_message = UP_DATA;
                        r.event_res  = EV_HIT;
                        if (kind == KIND_STORE)
                        begin
                            r.store_data = 1'b1;
                            nxt          = ST_M;
                        end
                        else
                        begin
                            nxt = cur;
                        end
                    end
                    else if (kind == KIND_REPLACE)
                    begin
                        if (!buffer_free)
                        begin
                            outcome = OC_STALL;
                            stall   = SR_POLL;
                        end
                        else
                        begin
                            alloc            = 1'b1;
                            alloc_state      = ST_MI;
                            r.buffer_command = BC_ALLOC;
                            r.down_first     = (cur == ST_E) ? DN_WB_CLEAN : DN_WB;
                            r.down_addr_only = (cur == ST_E);
                            r.event_res      = EV_WB_START;
                            nxt              = ST_I;
                        end
                    end
                    else if (kind == KIND_INV)
                    begin
                        r.up_message     = UP_INV;
                        r.down_first     = (cur == ST_E) ? DN_WB_CLEAN : DN_WB;
                        r.down_addr_only = (cur == ST_E);
                        nxt              = ST_I;
                    end
                    else if (kind == KIND_READ_FWD)
                    begin
                        r.down_first        = DN_DATA_SH;
                        r.down_to_requester = 1'b1;
                        nxt                 = ST_S;
                    end
                    else if (kind == KIND_READEX_FWD)
                    begin
                        r.down_first        = DN_DATA_EX;
                        r.down_to_requester = 1'b1;
                        nxt                 = ST_I;
                    end
                    else if (cur == ST_M)
                    begin
                        outcome = OC_IGNORE;
                    end
                    else
                    begin
                        outcome = OC_ERROR;
                    end
                end
                ST_SM:
                begin
                    if (kind == KIND_LOAD)
                    begin
                        r.up_message = UP_DATA;
                        r.event_res  = EV_HIT;
                        nxt          = cur;
                    end
                    else if (kind == KIND_STORE)
                    begin
                        if (!mshr_room)
                        begin
                            outcome = OC_STALL;
                            stall   = SR_EVENT;
                        end
                        else
                        begin
                            r.mshr_command = MS_ENQ;
                            nxt            = cur;
                            r.event_res    = EV_PART_HIT;
                        end
                    end
                    else if (kind == KIND_UPG_ACK)
                    begin
                        r.mshr_command = MS_DRAIN;
                        nxt            = ST_M;
                    end
                    else if (kind == KIND_INV)
                    begin
                        r.down_first         = DN_INV_ACK;
                        r.down_addr_only     = 1'b1;
                        r.down_second_readex = 1'b1;
                        nxt                  = ST_IM;
                    end
                    else if (kind == KIND_READ_FWD)
                    begin
                        r.down_first        = DN_DATA_SH;
                        r.down_to_requester = 1'b1;
                        nxt                 = cur;
                    end
                    else
                    begin
                        outcome = OC_ERROR;
                    end
                end
                ST_MI, ST_SI:
                begin
                    if (kind == KIND_LOAD && cur == ST_SI)
                    begin
                        r.up_message = UP_DATA;
                        r.event_res  = EV_HIT;
                        nxt          = cur;
                    end
                    else if (kind inside {KIND_LOAD, KIND_STORE})
                    begin
                        outcome = OC_STALL;
                        stall   = SR_EVENT;
                    end
                    else if (kind == KIND_INV || (cur == ST_MI && kind == KIND_WB_ACK)
                             || (cur == ST_SI && kind == KIND_REPL_ACK))
                    begin
                        r.buffer_command = BC_RELEASE;
                        r.up_message     = UP_INV;
                        r.event_res      = EV_WB_DONE;
                        nxt              = ST_I;
                    end
                    else if (kind == KIND_READ_FWD)
                    begin
                        r.down_first        = DN_DATA_SH;
                        r.down_to_requester = 1'b1;
                        r.down_addr_only    = 1'b1;
                        nxt                 = cur;
                    end
                    else if (kind == KIND_READEX_FWD && cur == ST_MI)
                    begin
                        r.down_first        = DN_DATA_EX;
                        r.down_to_requester = 1'b1;
                        r.down_addr_only    = 1'b1;
                        nxt                 = cur;
                    end
                    else
                    begin
                        outcome = OC_ERROR;
                    end
                end
                default:
                begin
                    outcome = OC_ERROR;
                end
            endcase
        end

        rsp = r;
        if (outcome != OC_TRANS)
        begin
            rsp           = '0;
            rsp.new_state = cur;
            if (outcome == OC_STALL)
            begin
                rsp.stall_res = stall;
                rsp.event_res = EV_STALL;
            end
            if (outcome == OC_ERROR)
            begin
                rsp.error = 1'b1;
            end
        end
        else
        begin
            rsp.new_state = nxt;
        end

        upd.trans       = (outcome == OC_TRANS);
        upd.nxt         = nxt;
        upd.alloc       = alloc;
        upd.alloc_state = alloc_state;
    end
endmodule

// ===== src/l1_coherence_line_controller.sv =====
`timescale 1ns / 1ps
// The line state of a taken request is read into a register; its response is then registered
// when the output is free; no request is taken during this read-modify-write of line state.
// A finished response waits in the output register while the next request is taken.
// Reset: all line and write-back buffer states read as Invalid; requests are taken at once,
// line entries are cleared by per-entry valid bits with no sweep.
module l1_coherence_line_controller (
    input  logic       clk,
    input  logic       rst_n,
    l1c_req_if.sink    req,
    l1c_rsp_if.source  rsp
);
    import l1c_pkg::*;

    logic                busy_reg;
    logic                busy_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;

    logic [KIND_W-1:0]   kind_reg;
    logic [WHERE_W-1:0]  where_reg;
    logic [LINE_AW-1:0]  li_reg;
    logic [BUF_AW-1:0]   bi_reg;
    logic [1:0]          ins_reg;
    logic                mfree_reg;
    logic                mroom_reg;
    logic                bfree_reg;

    logic [STATE_W-1:0]  buf_state_reg [WB_ENTRIES];

    logic                accept;
    logic                fire;
    logic [STATE_W-1:0]  line_rd;
    logic [STATE_W-1:0]  cur;
    rsp_t                t_rsp;
    upd_t                t_upd;
    logic                line_we;
    logic                buf_we;
    logic [STATE_W-1:0]  buf_wdata;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;
    assign fire      = busy_reg && (!out_valid_reg || rsp.ready);

    l1c_line_store u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (req.line_index[LINE_AW-1:0]),
        .rd_data (line_rd),
        .wr_en   (line_we),
        .wr_addr (li_reg),
        .wr_data (t_upd.nxt)
    );

    always_comb
    begin
        case (where_reg)
            LOC_CACHE:  cur = line_rd;
            LOC_BUFFER: cur = buf_state_reg[bi_reg];
            default:    cur = ST_NP;
        endcase
    end

    l1c_transition u_transition (
        .cur          (cur),
        .kind         (kind_reg),
        .insert_stall (ins_reg),
        .mshr_free    (mfree_reg),
        .mshr_room    (mroom_reg),
        .buffer_free  (bfree_reg),
        .rsp          (t_rsp),
        .upd          (t_upd)
    );

    // allocation of the buffer entry overrides its own next state
    assign line_we   = fire && t_upd.trans && (where_reg != LOC_BUFFER);
    assign buf_we    = fire && t_upd.trans && (t_upd.alloc || where_reg == LOC_BUFFER);
    assign buf_wdata = t_upd.alloc ? t_upd.alloc_state : t_upd.nxt;

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        rsp_next       = rsp_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            rsp_next       = t_rsp;
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WB_ENTRIES; i++)
            begin
                buf_state_reg[i] <= ST_I;
            end
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (buf_we)
            begin
                buf_state_reg[bi_reg] <= buf_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            kind_reg  <= req.kind;
            where_reg <= req.found_in;
            li_reg    <= req.line_index[LINE_AW-1:0];
            bi_reg    <= req.buffer_index[BUF_AW-1:0];
            ins_reg   <= req.insert_stall;
            mfree_reg <= req.mshr_free;
            mroom_reg <= req.mshr_room;
            bfree_reg <= req.buffer_free;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.new_state          = rsp_reg.new_state;
    assign rsp.stall_res          = rsp_reg.stall_res;
    assign rsp.error              = rsp_reg.error;
    assign rsp.down_first         = rsp_reg.down_first;
    assign rsp.down_to_requester  = rsp_reg.down_to_requester;
    assign rsp.down_addr_only     = rsp_reg.down_addr_only;
    assign rsp.down_second_readex = rsp_reg.down_second_readex;
    assign rsp.up_message         = rsp_reg.up_message;
    assign rsp.mshr_command       = rsp_reg.mshr_command;
    assign rsp.buffer_command     = rsp_reg.buffer_command;
    assign rsp.store_data         = rsp_reg.store_data;
    assign rsp.event_res          = rsp_reg.event_res;
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import l1c_pkg::*;

    localparam int DIR_ROWS        = 26;
    localparam int RANDOM_ITEMS    = 1680;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;

    typedef struct packed {
        logic [3:0] kind;
        logic [1:0] found_in;
        logic [7:0] line_index;
        logic [2:0] buffer_index;
        logic [1:0] insert_stall;
        logic       mshr_free;
        logic       mshr_room;
        logic       buffer_free;
    } req_item_t;

    // typed rows give the whole response: only these four fields can be nonzero
    typedef struct packed {
        logic       typed;
        req_item_t  item;
        logic [3:0] want_state;
        stall_t     want_stall;
        logic       want_err;
        event_t     want_event;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    l1c_req_if req_ch ();
    l1c_rsp_if rsp_ch ();

    l1_coherence_line_controller i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [3:0]  line_st [LINES];
    logic [3:0]  buf_st [WB_ENTRIES];
    rsp_t        pending_rsp [$];
    int unsigned failures = 0;
    int unsigned req_sent = 0;
    int unsigned rsp_checked = 0;
    int unsigned useful_items = 0;
    int unsigned stalls_seen = 0;
    int unsigned errors_seen = 0;
    int unsigned ignored_seen = 0;
    logic [9:0]  state_mask = '0;
    logic        hold_off_req = 1'b0;

    dir_row_t dir_table [DIR_ROWS] = '{
        // absent or invalid line: stalls, errors, ignored actions
        '{1'b1, '{KIND_LOAD, LOC_ABSENT, 8'd0, 3'd0, 2'd1, 1'b1, 1'b1, 1'b1},
          ST_NP, SR_POLL, 1'b0, EV_STALL},
        '{1'b1, '{KIND_STORE, LOC_ABSENT, 8'd0, 3'd0, 2'd2, 1'b1, 1'b1, 1'b1},
          ST_NP, SR_EVENT, 1'b0, EV_STALL},
        '{1'b1, '{KIND_LOAD, 2'd3, 8'd0, 3'd0, 2'd3, 1'b1, 1'b1, 1'b1},
          ST_NP, SR_EVENT, 1'b0, EV_STALL},
        '{1'b1, '{KIND_STORE, LOC_ABSENT, 8'd0, 3'd0, 2'd0, 1'b0, 1'b1, 1'b1},
          ST_NP, SR_POLL, 1'b0, EV_STALL},
        '{1'b1, '{4'd12, LOC_ABSENT, 8'd0, 3'd0, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_NP, SR_NONE, 1'b1, EV_NONE},
        '{1'b1, '{4'd15, LOC_CACHE, 8'd255, 3'd7, 2'd3, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b1, EV_NONE},
        '{1'b1, '{KIND_WB_ACK, LOC_ABSENT, 8'd1, 3'd1, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_NP, SR_NONE, 1'b0, EV_NONE},
        '{1'b1, '{KIND_INV, LOC_ABSENT, 8'd2, 3'd2, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_NP, SR_NONE, 1'b0, EV_NONE},
        '{1'b1, '{KIND_FLUSH, LOC_CACHE, 8'd0, 3'd0, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b1, EV_NONE},
        // line 0: miss, fill shared, upgrade, store hit in M, replace to entry 7
        '{1'b0, '{KIND_LOAD, LOC_CACHE, 8'd0, 3'd0, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        '{1'b0, '{KIND_DATA_SH, LOC_CACHE, 8'd0, 3'd0, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        '{1'b0, '{KIND_STORE, LOC_CACHE, 8'd0, 3'd0, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        '{1'b1, '{KIND_STORE, LOC_CACHE, 8'd0, 3'd0, 2'd0, 1'b1, 1'b0, 1'b1},
          ST_SM, SR_EVENT, 1'b0, EV_STALL},
        '{1'b0, '{KIND_UPG_ACK, LOC_CACHE, 8'd0, 3'd0, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        '{1'b0, '{KIND_STORE, LOC_CACHE, 8'd0, 3'd0, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        '{1'b1, '{KIND_REPLACE, LOC_CACHE, 8'd0, 3'd7, 2'd0, 1'b1, 1'b1, 1'b0},
          ST_M, SR_POLL, 1'b0, EV_STALL},
        '{1'b0, '{KIND_REPLACE, LOC_CACHE, 8'd0, 3'd7, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        '{1'b0, '{KIND_READ_FWD, LOC_BUFFER, 8'd0, 3'd7, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        '{1'b0, '{KIND_WB_ACK, LOC_BUFFER, 8'd0, 3'd7, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        // line 255: shared copy replaced to entry 0
        '{1'b0, '{KIND_LOAD, LOC_ABSENT, 8'd255, 3'd0, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        '{1'b0, '{KIND_DATA_SH, LOC_CACHE, 8'd255, 3'd0, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        '{1'b0, '{KIND_REPLACE, LOC_CACHE, 8'd255, 3'd0, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        '{1'b0, '{KIND_REPL_ACK, LOC_BUFFER, 8'd255, 3'd0, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        // line 128: exclusive copy invalidated
        '{1'b0, '{KIND_LOAD, LOC_CACHE, 8'd128, 3'd4, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        '{1'b0, '{KIND_DATA_EX, LOC_CACHE, 8'd128, 3'd4, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE},
        '{1'b0, '{KIND_INV, LOC_CACHE, 8'd128, 3'd4, 2'd0, 1'b1, 1'b1, 1'b1},
          ST_I, SR_NONE, 1'b0, EV_NONE}
    };

    function automatic logic [3:0] state_at(req_item_t it);
        logic [3:0] cur;
        case (it.found_in)
            LOC_CACHE:  cur = line_st[it.line_index % LINES];
            LOC_BUFFER: cur = buf_st[it.buffer_index % WB_ENTRIES];
            default:    cur = ST_NP;
        endcase
        return cur;
    endfunction

    function automatic rsp_t coherence_step(req_item_t it);
        rsp_t        r;
        logic [3:0]  cur;
        logic [3:0]  nxt;
        outcome_t    oc;
        stall_t      st;
        logic        alloc;
        line_state_t alloc_st;
        r        = '0;
        cur      = state_at(it);
        nxt      = ST_I;
        oc       = OC_TRANS;
        st       = SR_NONE;
        alloc    = 1'b0;
        alloc_st = ST_MI;
        if (it.kind > KIND_FLUSH)
        begin
            oc = OC_ERROR;
        end
        else
        begin
            case (cur)
                ST_NP, ST_I:
                begin
                    if (it.kind == KIND_LOAD || it.kind == KIND_STORE)
                    begin
                        if (cur == ST_NP && it.insert_stall != 2'd0)
                        begin
                            oc = OC_STALL;
                            st = (it.insert_stall == 2'd1) ? SR_POLL : SR_EVENT;
                        end
                        else if (!it.mshr_free || !it.mshr_room)
                        begin
                            oc = OC_STALL;
                            st = SR_POLL;
                        end
                        else
                        begin
                            r.mshr_command   = MS_ALLOC;
                            r.down_first     = (it.kind == KIND_LOAD) ? DN_READ : DN_READEX;
                            r.down_addr_only = 1'b1;
                            nxt              = (it.kind == KIND_LOAD) ? ST_ISE : ST_IM;
                            r.event_res      = EV_DEMAND_MISS;
                        end
                    end
                    else if (it.kind == KIND_WB_ACK || (cur == ST_NP && it.kind == KIND_INV))
                        oc = OC_IGNORE;
                    else
                        oc = OC_ERROR;
                end
                ST_IM, ST_ISE:
                begin
                    if (it.kind == KIND_DATA_EX || (cur == ST_ISE && it.kind == KIND_DATA_SH))
                    begin
                        r.store_data   = 1'b1;
                        r.mshr_command = MS_DRAIN;
                        if (cur == ST_IM)
                            nxt = ST_M;
                        else
                            nxt = (it.kind == KIND_DATA_SH) ? ST_S : ST_E;
                    end
                    else if (it.kind == KIND_READ_FWD || it.kind == KIND_READEX_FWD
                             || it.kind == KIND_INV
                             || (cur == ST_ISE && it.kind == KIND_STORE))
                    begin
                        oc = OC_STALL;
                        st = SR_EVENT;
                    end
                    else if (it.kind == KIND_LOAD || it.kind == KIND_STORE)
                    begin
                        if (!it.mshr_room)
                        begin
                            oc = OC_STALL;
                            st = SR_POLL;
                        end
                        else
                        begin
                            r.mshr_command = MS_ENQ;
                            nxt            = cur;
                            r.event_res    = EV_PART_HIT;
                        end
                    end
                    else if (it.kind == KIND_WB_ACK)
                        oc = OC_IGNORE;
                    else
                        oc = OC_ERROR;
                end
                ST_S:
                begin
                    if (it.kind == KIND_LOAD)
                    begin
                        r.up_message = UP_DATA;
                        r.event_res  = EV_HIT;
                        nxt          = ST_S;
                    end
                    else if (it.kind == KIND_STORE)
                    begin
                        if (!it.mshr_free || !it.mshr_room)
                        begin
                            oc = OC_STALL;
                            st = SR_POLL;
                        end
                        else
                        begin
                            r.mshr_command   = MS_ALLOC;
                            r.down_first     = DN_UPGRADE;
                            r.down_addr_only = 1'b1;
                            nxt              = ST_SM;
                            r.event_res      = EV_COH_MISS;
                        end
                    end
                    else if (it.kind == KIND_REPLACE)
                    begin
                        if (!it.buffer_free)
                        begin
                            oc = OC_STALL;
                            st = SR_POLL;
                        end
                        else
                        begin
                            alloc            = 1'b1;
                            alloc_st         = ST_SI;
                            r.buffer_command = BC_ALLOC;
                            r.down_first     = DN_REPLACE;
                            r.down_addr_only = 1'b1;
                            r.event_res      = EV_WB_START;
                            nxt              = ST_I;
                        end
                    end
                    else if (it.kind == KIND_READ_FWD)
                    begin
                        r.down_first        = DN_DATA_SH;
                        r.down_to_requester = 1'b1;
                        nxt                 = cur;
                    end
                    else if (it.kind == KIND_INV)
                    begin
                        r.down_first     = DN_INV_ACK;
                        r.down_addr_only = 1'b1;
                        r.up_message     = UP_INV;
                        nxt              = ST_I;
                    end
                    else if (it.kind == KIND_WB_ACK)
                        oc = OC_IGNORE;
                    else
                        oc = OC_ERROR;
                end
                ST_E, ST_M:
                begin
                    if (it.kind == KIND_LOAD || it.kind == KIND_STORE)
                    begin
                        r.up_message = UP_DATA;
                        r.event_res  = EV_HIT;
                        if (it.kind == KIND_STORE)
                        begin
                            r.store_data = 1'b1;
                            nxt          = ST_M;
                        end
                        else
                            nxt = cur;
                    end
                    else if (it.kind == KIND_REPLACE && !it.buffer_free)
                    begin
                        oc = OC_STALL;
                        st = SR_POLL;
                    end
                    else if (it.kind == KIND_REPLACE || it.kind == KIND_INV)
                    begin
                        if (it.kind == KIND_REPLACE)
                        begin
                            alloc            = 1'b1;
                            alloc_st         = ST_MI;
                            r.buffer_command = BC_ALLOC;
                            r.event_res      = EV_WB_START;
                        end
                        else
                            r.up_message = UP_INV;
                        r.down_first     = (cur == ST_E) ? DN_WB_CLEAN : DN_WB;
                        r.down_addr_only = (cur == ST_E);
                        nxt              = ST_I;
                    end
                    else if (it.kind == KIND_READ_FWD || it.kind == KIND_READEX_FWD)
                    begin
                        r.down_first = (it.kind == KIND_READ_FWD) ? DN_DATA_SH : DN_DATA_EX;
                        r.down_to_requester = 1'b1;
                        nxt = (it.kind == KIND_READ_FWD) ? ST_S : ST_I;
                    end
                    else if (cur == ST_M)
                        oc = OC_IGNORE;
                    else
                        oc = OC_ERROR;
                end
                ST_SM:
                begin
                    if (it.kind == KIND_LOAD)
                    begin
                        r.up_message = UP_DATA;
                        r.event_res  = EV_HIT;
                        nxt          = cur;
                    end
                    else if (it.kind == KIND_STORE)
                    begin
                        if (!it.mshr_room)
                        begin
                            oc = OC_STALL;
                            st = SR_EVENT;
                        end
                        else
                        begin
                            r.mshr_command = MS_ENQ;
                            nxt            = cur;
                            r.event_res    = EV_PART_HIT;
                        end
                    end
                    else if (it.kind == KIND_UPG_ACK)
                    begin
                        r.mshr_command = MS_DRAIN;
                        nxt            = ST_M;
                    end
                    else if (it.kind == KIND_INV)
                    begin
                        r.down_first         = DN_INV_ACK;
                        r.down_addr_only     = 1'b1;
                        r.down_second_readex = 1'b1;
                        nxt                  = ST_IM;
                    end
                    else if (it.kind == KIND_READ_FWD)
                    begin
                        r.down_first        = DN_DATA_SH;
                        r.down_to_requester = 1'b1;
                        nxt                 = cur;
                    end
                    else
                        oc = OC_ERROR;
                end
                ST_MI, ST_SI:
                begin
                    if (it.kind == KIND_LOAD && cur == ST_SI)
                    begin
                        r.up_message = UP_DATA;
                        r.event_res  = EV_HIT;
                        nxt          = cur;
                    end
                    else if (it.kind == KIND_LOAD || it.kind == KIND_STORE)
                    begin
                        oc = OC_STALL;
                        st = SR_EVENT;
                    end
                    else if (it.kind == KIND_INV || (cur == ST_MI && it.kind == KIND_WB_ACK)
                             || (cur == ST_SI && it.kind == KIND_REPL_ACK))
                    begin
                        r.buffer_command = BC_RELEASE;
                        r.up_message     = UP_INV;
                        r.event_res      = EV_WB_DONE;
                        nxt              = ST_I;
                    end
                    else if (it.kind == KIND_READ_FWD
                             || (it.kind == KIND_READEX_FWD && cur == ST_MI))
                    begin
                        r.down_first = (it.kind == KIND_READ_FWD) ? DN_DATA_SH : DN_DATA_EX;
                        r.down_to_requester = 1'b1;
                        r.down_addr_only    = 1'b1;
                        nxt                 = cur;
                    end
                    else
                        oc = OC_ERROR;
                end
                default:
                    oc = OC_ERROR;
            endcase
        end

        if (oc != OC_TRANS)
        begin
            r           = '0;
            r.new_state = cur;
            if (oc == OC_STALL)
            begin
                r.stall_res = st;
                r.event_res = EV_STALL;
            end
            if (oc == OC_ERROR)
                r.error = 1'b1;
        end
        else
        begin
            r.new_state = nxt;
            if (it.found_in == LOC_BUFFER)
                buf_st[it.buffer_index % WB_ENTRIES] = nxt;
            else
                line_st[it.line_index % LINES] = nxt;
            // allocation lands after the entry's own update
            if (alloc)
                buf_st[it.buffer_index % WB_ENTRIES] = alloc_st;
        end
        return r;
    endfunction

    // mostly actions that move the line along from where it stands now
    function automatic logic [3:0] pick_kind(logic [3:0] cur);
        kind_t opts[$];
        case (cur)
            ST_NP, ST_I: opts = '{KIND_LOAD, KIND_STORE, KIND_LOAD, KIND_STORE, KIND_WB_ACK};
            ST_IM:  opts = '{KIND_DATA_EX, KIND_DATA_EX, KIND_LOAD, KIND_STORE, KIND_INV,
                             KIND_READ_FWD};
            ST_ISE: opts = '{KIND_DATA_SH, KIND_DATA_EX, KIND_LOAD, KIND_STORE, KIND_INV};
            ST_S:   opts = '{KIND_LOAD, KIND_STORE, KIND_REPLACE, KIND_READ_FWD, KIND_INV};
            ST_E, ST_M: opts = '{KIND_LOAD, KIND_STORE, KIND_REPLACE, KIND_INV,
                                 KIND_READ_FWD, KIND_READEX_FWD};
            ST_SM:  opts = '{KIND_LOAD, KIND_STORE, KIND_UPG_ACK, KIND_INV, KIND_READ_FWD};
            ST_MI:  opts = '{KIND_LOAD, KIND_WB_ACK, KIND_INV, KIND_READ_FWD,
                             KIND_READEX_FWD};
            default: opts = '{KIND_LOAD, KIND_REPL_ACK, KIND_INV, KIND_READ_FWD};
        endcase
        return opts[$urandom_range(0, opts.size() - 1)];
    endfunction

    task automatic offer(input req_item_t it, input logic from_table, input rsp_t want);
        rsp_t r;
        rsp_t z;
        @(negedge clk);
        req_ch.valid        = 1'b1;
        req_ch.kind         = it.kind;
        req_ch.found_in     = it.found_in;
        req_ch.line_index   = it.line_index;
        req_ch.buffer_index = it.buffer_index;
        req_ch.insert_stall = it.insert_stall;
        req_ch.mshr_free    = it.mshr_free;
        req_ch.mshr_room    = it.mshr_room;
        req_ch.buffer_free  = it.buffer_free;
        do @(posedge clk); while (!req_ch.ready);
        r = coherence_step(it);
        if (from_table)
            r = want;
        pending_rsp.push_back(r);
        req_sent++;
        state_mask[r.new_state] = 1'b1;
        z = r;
        z.new_state = '0;
        if (z == '0)
            ignored_seen++;
        else
            useful_items++;
        if (r.event_res == EV_STALL)
            stalls_seen++;
        if (r.error)
            errors_seen++;
    endtask

    function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin : response_check
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response transfer with no request outstanding");
                failures++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("new_state", want.new_state, rsp_ch.new_state);
                check_field("stall_res", want.stall_res, rsp_ch.stall_res);
                check_field("error", want.error, rsp_ch.error);
                check_field("down_first", want.down_first, rsp_ch.down_first);
                check_field("down_to_requester", want.down_to_requester,
                            rsp_ch.down_to_requester);
                check_field("down_addr_only", want.down_addr_only, rsp_ch.down_addr_only);
                check_field("down_second_readex", want.down_second_readex,
                            rsp_ch.down_second_readex);
                check_field("up_message", want.up_message, rsp_ch.up_message);
                check_field("mshr_command", want.mshr_command, rsp_ch.mshr_command);
                check_field("buffer_command", want.buffer_command, rsp_ch.buffer_command);
                check_field("store_data", want.store_data, rsp_ch.store_data);
                check_field("event_res", want.event_res, rsp_ch.event_res);
                rsp_checked++;
            end
        end
    end

    initial
    begin : receiver
        int unsigned mode;
        int unsigned tick;
        logic        hold_done;
        mode      = 0;
        tick      = 0;
        hold_done = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_done)
            begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (tick % 48 == 0)
                    mode = $urandom_range(0, 3);
                tick++;
                case (mode)
                    0:       rsp_ch.ready = 1'b1;
                    1:       rsp_ch.ready = ($urandom_range(0, 9) >= 3);
                    2:       rsp_ch.ready = (tick % 3 == 0);
                    default: rsp_ch.ready = ($urandom_range(0, 9) >= 7);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0]  hot_lines [6];
        req_item_t   it;
        rsp_t        want;
        logic [3:0]  cur;
        int unsigned pick;
        int unsigned target;
        int unsigned burst;
        int unsigned gap;
        int unsigned bursts;
        logic        hold_started;
        logic        pause_done;

        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = '0;
        req_ch.found_in     = '0;
        req_ch.line_index   = '0;
        req_ch.buffer_index = '0;
        req_ch.insert_stall = '0;
        req_ch.mshr_free    = 1'b0;
        req_ch.mshr_room    = 1'b0;
        req_ch.buffer_free  = 1'b0;
        foreach (line_st[i])
            line_st[i] = ST_I;
        foreach (buf_st[i])
            buf_st[i] = ST_I;
        hot_lines[0] = 8'd0;
        hot_lines[1] = 8'd255;
        for (int i = 2; i < 6; i++)
            hot_lines[i] = 8'($urandom_range(0, 255));
        bursts       = 0;
        hold_started = 1'b0;
        pause_done   = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        foreach (dir_table[i])
        begin
            want            = '0;
            want.new_state  = dir_table[i].want_state;
            want.stall_res  = dir_table[i].want_stall;
            want.error      = dir_table[i].want_err;
            want.event_res  = dir_table[i].want_event;
            offer(dir_table[i].item, dir_table[i].typed, want);
        end

        // let the directed part drain before random traffic
        @(negedge clk) req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);

        target = req_sent + RANDOM_ITEMS;
        while (req_sent < target)
        begin
            burst = (bursts % 4 == 3) ? $urandom_range(30, 60) : $urandom_range(1, 16);
            repeat (burst)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    it.found_in = LOC_CACHE;
                else if (pick < 80)
                    it.found_in = LOC_BUFFER;
                else if (pick < 95)
                    it.found_in = LOC_ABSENT;
                else
                    it.found_in = 2'd3;
                if ($urandom_range(0, 3) == 0)
                    it.line_index = 8'($urandom_range(0, 255));
                else
                    it.line_index = hot_lines[$urandom_range(0, 5)];
                it.buffer_index = 3'($urandom_range(0, WB_ENTRIES - 1));
                cur = state_at(it);
                if ($urandom_range(0, 4) == 0)
                    it.kind = 4'($urandom_range(0, 15));
                else
                    it.kind = pick_kind(cur);
                if ($urandom_range(0, 4) == 0)
                    it.insert_stall = 2'($urandom_range(0, 3));
                else
                    it.insert_stall = 2'd0;
                it.mshr_free   = ($urandom_range(0, 6) != 0);
                it.mshr_room   = ($urandom_range(0, 6) != 0);
                it.buffer_free = ($urandom_range(0, 6) != 0);
                offer(it, 1'b0, '0);
            end
            if (!hold_started && req_sent + 2 * RANDOM_ITEMS / 3 > target)
            begin
                hold_off_req = 1'b1;
                hold_started = 1'b1;
            end
            if (!pause_done && req_sent + RANDOM_ITEMS / 3 > target)
            begin
                @(negedge clk) req_ch.valid = 1'b0;
                while (pending_rsp.size() != 0)
                    @(posedge clk);
                pause_done = 1'b1;
            end
            gap = (bursts % 4 == 3) ? 0 : $urandom_range(0, 6);
            repeat (gap) @(negedge clk) req_ch.valid = 1'b0;
            bursts++;
        end

        @(negedge clk) req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d requests (%0d from the directed table, %0d acting), %0d compared",
                 req_sent, DIR_ROWS, useful_items, rsp_checked);
        $display("run: %0d stalls, %0d errors, %0d ignored actions, next states seen %b",
                 stalls_seen, errors_seen, ignored_seen, state_mask);
        if (failures == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
